// ===== src/mcrt_pkg.sv =====
package mcrt_pkg;

  // field widths
  localparam int unsigned KindW    = 3;
  localparam int unsigned ElapsedW = 8;
  localparam int unsigned PeriodW  = 12;
  localparam int unsigned AccumW   = 13;
  localparam int unsigned TimeW    = 6;

  // fixed values of the timer
  localparam logic [PeriodW-1:0] PeriodReset = 12'd1000;
  localparam logic [TimeW-1:0]   TimeMax     = 6'd59;
  localparam logic [TimeW-1:0]   SecStep     = 6'd5;
  localparam logic [TimeW-1:0]   SecWrapLow  = 6'd55;

  // button codes, codes 6 and 7 act as no button
  typedef enum logic [KindW-1:0] {
    KIND_NONE       = 3'd0,
    KIND_START_STOP = 3'd1,
    KIND_MIN_UP     = 3'd2,
    KIND_MIN_DOWN   = 3'd3,
    KIND_SEC_UP     = 3'd4,
    KIND_SEC_DOWN   = 3'd5
  } kind_t;

  // timer state carried from one scan pass to the next
  typedef struct packed {
    logic [TimeW-1:0]  set_min;
    logic [TimeW-1:0]  set_sec;
    logic [TimeW-1:0]  left_min;
    logic [TimeW-1:0]  left_sec;
    logic              running;
    logic              start_armed;
    logic [AccumW-1:0] ms_accum;
  } timer_state_t;

  // one result beat
  typedef struct packed {
    logic             relay_on;
    logic             show_remaining;
    logic [TimeW-1:0] shown_min;
    logic [TimeW-1:0] shown_sec;
  } timer_result_t;

endpackage

// ===== src/mmss_countdown_relay_timer_unit.sv =====
// channel | dir | signals                        | content
// in      | in  | in_tvalid/in_tready/in_tdata   | tuser: kind, tdata: elapsed_ms
// out     | out | out_tvalid/out_tready/out_tdata| tuser: show_remaining, tdata: rest
// cfg     | in  | cfg_valid/cfg_ready/cfg_data   | second_period_ms
//
// one beat per cycle sustained while the output is not stalled; an accepted beat passes through
// the input register, then the step logic, into the result register
// the timer state register is updated as each beat moves into the result register
// rst_n is synchronous and active low; period resets to 1000 ms, time to 00:00
// a stalled output holds its beat; the input register refills while the output drains
module mmss_countdown_relay_timer_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] elapsed_ms
  input  logic [2:0]  in_tuser,   // [2:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [0] relay_on, [6:1] shown_minutes,
                                  // [12:7] shown_seconds, [15:13] zero
  output logic        out_tuser,  // [0] show_remaining
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [11:0] cfg_data    // [11:0] second_period_ms
);
  import mcrt_pkg::*;

  logic                s1_valid_r;
  logic [KindW-1:0]    s1_kind_r;
  logic [ElapsedW-1:0] s1_elapsed_r;
  logic                out_valid_r;
  timer_result_t       out_res_r;
  timer_result_t       res_nxt;
  timer_state_t        state_r;
  timer_state_t        state_nxt;
  logic [PeriodW-1:0]  period_r;
  logic                advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  // period register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PeriodReset;
    end else if (cfg_valid) begin
      period_r <= cfg_data;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_kind_r    <= in_tuser;
      s1_elapsed_r <= in_tdata;
    end
  end

  // step logic
  mcrt_step u_step (
    .cur_i     (state_r),
    .kind_i    (s1_kind_r),
    .elapsed_i (s1_elapsed_r),
    .period_i  (period_r),
    .nxt_o     (state_nxt),
    .res_o     (res_nxt)
  );

  // timer state, start/stop armed out of reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{start_armed: 1'b1, default: '0};
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.show_remaining;
  assign out_tdata  = {3'b000, out_res_r.shown_sec, out_res_r.shown_min,
                       out_res_r.relay_on};

`ifndef ASSERT_OFF
  // a running timer always has time left
  a_running_left: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.running |-> ((state_r.left_min != '0) || (state_r.left_sec != '0)))
    else $error("timer running at 00:00");

  // set time stays in range
  a_set_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.set_min <= TimeMax) && (state_r.set_sec <= TimeMax))
    else $error("set time out of range");

  // remaining time stays in range
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.left_min <= TimeMax) && (state_r.left_sec <= TimeMax))
    else $error("remaining time out of range");

  // state only moves when a beat passes into the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!advance && $past(rst_n)) |=> $stable(state_r))
    else $error("timer state changed without a beat");
`endif

endmodule

// ===== src/mcrt_step.sv =====
module mcrt_step (
  input  mcrt_pkg::timer_state_t              cur_i,
  input  logic [mcrt_pkg::KindW-1:0]          kind_i,
  input  logic [mcrt_pkg::ElapsedW-1:0]       elapsed_i,
  input  logic [mcrt_pkg::PeriodW-1:0]        period_i,
  output mcrt_pkg::timer_state_t              nxt_o,
  output mcrt_pkg::timer_result_t             res_o
);
  import mcrt_pkg::*;

  kind_t             kind_e;
  logic              pressed;
  logic              just_started;
  logic [TimeW:0]    sec_sum;
  logic [AccumW-1:0] acc_sum;
  timer_state_t      st;

  assign kind_e  = kind_t'(kind_i);
  assign pressed = (kind_i >= KIND_START_STOP) && (kind_i <= KIND_SEC_DOWN);
  assign sec_sum = {1'b0, cur_i.set_sec} + {1'b0, SecStep};
  assign acc_sum = cur_i.ms_accum + {{(AccumW-ElapsedW){1'b0}}, elapsed_i};

  // next state for one scan pass
  always_comb begin
    st           = cur_i;
    just_started = 1'b0;

    // button action
    unique case (kind_e)
      KIND_START_STOP: begin
        if (cur_i.start_armed) begin
          if (cur_i.running) begin
            st.running = 1'b0;
            st.set_min = '0;
            st.set_sec = '0;
          end else begin
            st.running   = 1'b1;
            just_started = 1'b1;
            st.left_min  = cur_i.set_min;
            st.left_sec  = cur_i.set_sec;
            st.ms_accum  = '0;
          end
          st.start_armed = 1'b0;
        end
      end
      KIND_MIN_UP: begin
        st.set_min = (cur_i.set_min >= TimeMax) ? '0 : cur_i.set_min + 6'd1;
      end
      KIND_MIN_DOWN: begin
        st.set_min = (cur_i.set_min == '0) ? TimeMax : cur_i.set_min - 6'd1;
      end
      KIND_SEC_UP: begin
        if (sec_sum > {1'b0, TimeMax}) begin
          st.set_sec = '0;
          st.set_min = (cur_i.set_min < TimeMax) ? cur_i.set_min + 6'd1 : TimeMax;
        end else begin
          st.set_sec = sec_sum[TimeW-1:0];
        end
      end
      KIND_SEC_DOWN: begin
        if (cur_i.set_sec < SecStep) begin
          st.set_sec = SecWrapLow;
          if (cur_i.set_min != '0) begin
            st.set_min = cur_i.set_min - 6'd1;
          end
        end else begin
          st.set_sec = cur_i.set_sec - SecStep;
        end
      end
      default: begin
      end
    endcase

    // countdown
    if (st.running) begin
      if (!just_started) begin
        st.ms_accum = acc_sum;
        if (acc_sum > {1'b0, period_i}) begin
          if (st.left_sec == '0) begin
            st.left_sec = TimeMax;
            if (st.left_min != '0) begin
              st.left_min = st.left_min - 6'd1;
            end
          end else begin
            st.left_sec = st.left_sec - 6'd1;
          end
          st.ms_accum = '0;
        end
      end
      if ((st.left_min == '0) && (st.left_sec == '0)) begin
        st.running = 1'b0;
        st.set_min = '0;
        st.set_sec = '0;
      end
    end

    // a pass with no button re-arms start/stop
    if (!pressed) begin
      st.start_armed = 1'b1;
    end
  end

  assign nxt_o = st;

  // display and relay follow the state after the pass
  assign res_o.relay_on       = st.running;
  assign res_o.show_remaining = st.running;
  assign res_o.shown_min      = st.running ? st.left_min : st.set_min;
  assign res_o.shown_sec      = st.running ? st.left_sec : st.set_sec;

endmodule
